### sv/dbbs_pkg.sv
// ----------------------------------------------------------------------------
// Detection best-box selector package
// Shared constants, register codes and stage types of the selector.
// ----------------------------------------------------------------------------
package dbbs_pkg;

   localparam int unsigned CANDIDATE_LIMIT = 500;
   localparam int unsigned CNT_W = 13;

   localparam logic signed [16:0] ONE_Q15 = 17'sd32768;

   typedef enum logic [2:0] {
      REG_SCREEN_WIDTH    = 3'd0,
      REG_SCREEN_HEIGHT   = 3'd1,
      REG_SCORE_THRESHOLD = 3'd2,
      REG_MIN_BOX_WIDTH   = 3'd3,
      REG_MAX_BOX_WIDTH   = 3'd4,
      REG_MIN_BOX_HEIGHT  = 3'd5,
      REG_MAX_BOX_HEIGHT  = 3'd6,
      REG_EDGE_MARGIN     = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [11:0] screen_width;
      logic [11:0] screen_height;
      logic [15:0] score_floor;
      logic [11:0] min_box_width;
      logic [11:0] max_box_width;
      logic [11:0] min_box_height;
      logic [11:0] max_box_height;
      logic [7:0]  edge_margin;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      screen_width:    12'd320,
      screen_height:   12'd240,
      score_floor:     16'd16384,
      min_box_width:   12'd30,
      max_box_width:   12'd250,
      min_box_height:  12'd40,
      max_box_height:  12'd220,
      edge_margin:     8'd5
   };

   typedef struct packed {
      logic [15:0] score;
      logic [11:0] left;
      logic [11:0] top;
      logic [11:0] width;
      logic [11:0] height;
      logic        pass;
      logic        last;
   } cand_type;

endpackage

### sv/dbbs_csr.sv
// ----------------------------------------------------------------------------
// Selector configuration registers
// Holds the screen size, score threshold, size windows and clamp margin.
// ----------------------------------------------------------------------------
module dbbs_csr (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [2:0]          csr_index,
   input  logic [15:0]         csr_data,
   output dbbs_pkg::cfg_type   cfg
);

   dbbs_pkg::cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= dbbs_pkg::CFG_RESET;
      end else if (csr_valid) begin
         unique case (dbbs_pkg::csr_index_type'(csr_index))
            dbbs_pkg::REG_SCREEN_WIDTH:    cfg_ff.screen_width    <= csr_data[11:0];
            dbbs_pkg::REG_SCREEN_HEIGHT:   cfg_ff.screen_height   <= csr_data[11:0];
            dbbs_pkg::REG_SCORE_THRESHOLD: cfg_ff.score_floor     <= csr_data;
            dbbs_pkg::REG_MIN_BOX_WIDTH:   cfg_ff.min_box_width   <= csr_data[11:0];
            dbbs_pkg::REG_MAX_BOX_WIDTH:   cfg_ff.max_box_width   <= csr_data[11:0];
            dbbs_pkg::REG_MIN_BOX_HEIGHT:  cfg_ff.min_box_height  <= csr_data[11:0];
            dbbs_pkg::REG_MAX_BOX_HEIGHT:  cfg_ff.max_box_height  <= csr_data[11:0];
            dbbs_pkg::REG_EDGE_MARGIN:     cfg_ff.edge_margin     <= csr_data[7:0];
            default: cfg_ff <= cfg_ff;
         endcase
      end
   end

endmodule

### sv/dbbs_scale.sv
// ----------------------------------------------------------------------------
// Selector candidate scaling stage
// Registers each request, checks its score and corners, and scales the
// corners to pixels.
// ----------------------------------------------------------------------------
module dbbs_scale (
   input  logic                    clock,
   input  logic                    reset,
   input  dbbs_pkg::cfg_type       cfg,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [15:0]             req_score,
   input  logic signed [16:0]      req_left_norm,
   input  logic signed [16:0]      req_top_norm,
   input  logic signed [16:0]      req_right_norm,
   input  logic signed [16:0]      req_bottom_norm,
   input  logic                    req_last,
   output logic                    cand_valid,
   output dbbs_pkg::cand_type      cand,
   input  logic                    cand_go
);

   logic                   in_valid_ff;
   logic [15:0]            score_ff;
   logic signed [16:0]     left_ff;
   logic signed [16:0]     top_ff;
   logic signed [16:0]     right_ff;
   logic signed [16:0]     bottom_ff;
   logic                   last_ff;

   logic                   cand_valid_ff;
   dbbs_pkg::cand_type     cand_ff;
   dbbs_pkg::cand_type     cand_in;

   logic                   out_ready;
   logic                   in_ready;
   logic                   geom_ok;
   logic [27:0]            x1_prod;
   logic [27:0]            y1_prod;
   logic [27:0]            x2_prod;
   logic [27:0]            y2_prod;
   logic [11:0]            x1;
   logic [11:0]            y1;
   logic [11:0]            x2;
   logic [11:0]            y2;

   assign out_ready = !cand_valid_ff || cand_go;
   assign in_ready  = !in_valid_ff || out_ready;
   assign req_stall = !in_ready;

   assign cand_valid = cand_valid_ff;
   assign cand       = cand_ff;

   always_comb begin
      geom_ok = !left_ff[16] && !top_ff[16] &&
                (right_ff <= dbbs_pkg::ONE_Q15) && (bottom_ff <= dbbs_pkg::ONE_Q15) &&
                (right_ff > left_ff) && (bottom_ff > top_ff);
      x1_prod = 28'(left_ff[15:0])   * 28'(cfg.screen_width);
      y1_prod = 28'(top_ff[15:0])    * 28'(cfg.screen_height);
      x2_prod = 28'(right_ff[15:0])  * 28'(cfg.screen_width);
      y2_prod = 28'(bottom_ff[15:0]) * 28'(cfg.screen_height);
      x1 = x1_prod[26:15];
      y1 = y1_prod[26:15];
      x2 = x2_prod[26:15];
      y2 = y2_prod[26:15];
      cand_in.score  = score_ff;
      cand_in.left   = x1;
      cand_in.top    = y1;
      cand_in.width  = x2 - x1;
      cand_in.height = y2 - y1;
      cand_in.pass   = geom_ok && (score_ff > cfg.score_floor);
      cand_in.last   = last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         cand_valid_ff <= 1'b0;
      end else begin
         if (in_ready) begin
            in_valid_ff <= req_valid;
         end
         if (out_ready) begin
            cand_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && req_valid) begin
         score_ff  <= req_score;
         left_ff   <= req_left_norm;
         top_ff    <= req_top_norm;
         right_ff  <= req_right_norm;
         bottom_ff <= req_bottom_norm;
         last_ff   <= req_last;
      end
      if (out_ready && in_valid_ff) begin
         cand_ff <= cand_in;
      end
   end

endmodule

### sv/dbbs_select.sv
// ----------------------------------------------------------------------------
// Selector best-box stage
// Keeps the highest-scoring accepted box of a frame and produces the clamped
// result at the end of the frame.
// ----------------------------------------------------------------------------
module dbbs_select (
   input  logic                    clock,
   input  logic                    reset,
   input  dbbs_pkg::cfg_type       cfg,
   input  logic                    cand_valid,
   input  dbbs_pkg::cand_type      cand,
   output logic                    cand_go,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_found,
   output logic [11:0]             rsp_box_x,
   output logic [11:0]             rsp_box_y,
   output logic [11:0]             rsp_box_width,
   output logic [11:0]             rsp_box_height,
   output logic [15:0]             rsp_best_score
);

   localparam logic [dbbs_pkg::CNT_W-1:0] LIMIT = dbbs_pkg::CNT_W'(dbbs_pkg::CANDIDATE_LIMIT);
   localparam logic [dbbs_pkg::CNT_W-1:0] STEP  = dbbs_pkg::CNT_W'(1);

   logic [15:0]                  kept_score_ff;
   logic [11:0]                  kept_left_ff;
   logic [11:0]                  kept_top_ff;
   logic [11:0]                  kept_width_ff;
   logic [11:0]                  kept_height_ff;
   logic                         any_accepted_ff;
   logic [dbbs_pkg::CNT_W-1:0]   index_ff;

   logic [15:0]                  kept_score_in;
   logic [11:0]                  kept_left_in;
   logic [11:0]                  kept_top_in;
   logic [11:0]                  kept_width_in;
   logic [11:0]                  kept_height_in;
   logic                         any_accepted_in;
   logic [dbbs_pkg::CNT_W-1:0]   index_in;

   logic                         rsp_valid_ff;
   logic                         found_ff;
   logic [11:0]                  box_x_ff;
   logic [11:0]                  box_y_ff;
   logic [11:0]                  box_width_ff;
   logic [11:0]                  box_height_ff;
   logic [15:0]                  top_score_ff;

   logic                         out_free;
   logic                         take;
   logic                         emit;
   logic                         emit_go;
   logic                         found;
   logic signed [13:0]           margin;
   logic signed [13:0]           hi_x;
   logic signed [13:0]           hi_y;
   logic signed [13:0]           pos_x;
   logic signed [13:0]           pos_y;
   logic signed [13:0]           clamp_x;
   logic signed [13:0]           clamp_y;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      take = cand.pass &&
             (cand.width >= cfg.min_box_width) && (cand.width <= cfg.max_box_width) &&
             (cand.height >= cfg.min_box_height) && (cand.height <= cfg.max_box_height) &&
             (cand.score > kept_score_ff);
      index_in = index_ff + STEP;
      emit     = cand.last || (index_in >= LIMIT);
      cand_go  = cand_valid && (!emit || out_free);
      emit_go  = cand_go && emit;

      if (take) begin
         kept_score_in   = cand.score;
         kept_left_in    = cand.left;
         kept_top_in     = cand.top;
         kept_width_in   = cand.width;
         kept_height_in  = cand.height;
         any_accepted_in = 1'b1;
      end else begin
         kept_score_in   = kept_score_ff;
         kept_left_in    = kept_left_ff;
         kept_top_in     = kept_top_ff;
         kept_width_in   = kept_width_ff;
         kept_height_in  = kept_height_ff;
         any_accepted_in = any_accepted_ff;
      end

      found  = any_accepted_in && (kept_score_in > cfg.score_floor);
      margin = $signed({6'b0, cfg.edge_margin});
      hi_x   = $signed({2'b0, cfg.screen_width}) - $signed({2'b0, kept_width_in}) - margin;
      hi_y   = $signed({2'b0, cfg.screen_height}) - $signed({2'b0, kept_height_in}) - margin;
      pos_x  = $signed({2'b0, kept_left_in});
      pos_y  = $signed({2'b0, kept_top_in});
      clamp_x = (pos_x < hi_x) ? pos_x : hi_x;
      clamp_y = (pos_y < hi_y) ? pos_y : hi_y;
      if (!(clamp_x > margin)) begin
         clamp_x = margin;
      end
      if (!(clamp_y > margin)) begin
         clamp_y = margin;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kept_score_ff   <= '0;
         kept_left_ff    <= '0;
         kept_top_ff     <= '0;
         kept_width_ff   <= '0;
         kept_height_ff  <= '0;
         any_accepted_ff <= 1'b0;
         index_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (cand_go) begin
            if (emit) begin
               kept_score_ff   <= '0;
               kept_left_ff    <= '0;
               kept_top_ff     <= '0;
               kept_width_ff   <= '0;
               kept_height_ff  <= '0;
               any_accepted_ff <= 1'b0;
               index_ff        <= '0;
            end else begin
               kept_score_ff   <= kept_score_in;
               kept_left_ff    <= kept_left_in;
               kept_top_ff     <= kept_top_in;
               kept_width_ff   <= kept_width_in;
               kept_height_ff  <= kept_height_in;
               any_accepted_ff <= any_accepted_in;
               index_ff        <= index_in;
            end
         end
         if (out_free) begin
            rsp_valid_ff <= emit_go;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit_go) begin
         found_ff      <= found;
         box_x_ff      <= found ? clamp_x[11:0] : 12'd0;
         box_y_ff      <= found ? clamp_y[11:0] : 12'd0;
         box_width_ff  <= found ? kept_width_in : 12'd0;
         box_height_ff <= found ? kept_height_in : 12'd0;
         top_score_ff  <= found ? kept_score_in : 16'd0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = found_ff;
   assign rsp_box_x      = box_x_ff;
   assign rsp_box_y      = box_y_ff;
   assign rsp_box_width  = box_width_ff;
   assign rsp_box_height = box_height_ff;
   assign rsp_best_score = top_score_ff;

endmodule

### sv/detection_best_box_selector_top.sv
// ----------------------------------------------------------------------------
// Detection best-box selector
// Picks the highest-scoring valid detector box of each frame. One candidate
// request is accepted per clock cycle unless the pipeline stops; a request
// passes an input register, a scaling register with the four corner
// multipliers, and the best-box stage. The rate is set by the compare and
// update of the kept box in the best-box stage. A frame ends on a request
// with last set or on its 500th request. The pipeline stops only while a
// result waits at a stalled output.
// ----------------------------------------------------------------------------
module detection_best_box_selector_top (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [15:0]          req_score,
   input  logic signed [16:0]   req_left_norm,
   input  logic signed [16:0]   req_top_norm,
   input  logic signed [16:0]   req_right_norm,
   input  logic signed [16:0]   req_bottom_norm,
   input  logic                 req_last,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_found,
   output logic [11:0]          rsp_box_x,
   output logic [11:0]          rsp_box_y,
   output logic [11:0]          rsp_box_width,
   output logic [11:0]          rsp_box_height,
   output logic [15:0]          rsp_best_score,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [2:0]           csr_index,
   input  logic [15:0]          csr_data
);

   dbbs_pkg::cfg_type    cfg;
   dbbs_pkg::cand_type   cand;
   logic                 cand_valid;
   logic                 cand_go;

   dbbs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   dbbs_scale u_scale (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_score       (req_score),
      .req_left_norm   (req_left_norm),
      .req_top_norm    (req_top_norm),
      .req_right_norm  (req_right_norm),
      .req_bottom_norm (req_bottom_norm),
      .req_last        (req_last),
      .cand_valid      (cand_valid),
      .cand            (cand),
      .cand_go         (cand_go)
   );

   dbbs_select u_select (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .cand_valid     (cand_valid),
      .cand           (cand),
      .cand_go        (cand_go),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_found      (rsp_found),
      .rsp_box_x      (rsp_box_x),
      .rsp_box_y      (rsp_box_y),
      .rsp_box_width  (rsp_box_width),
      .rsp_box_height (rsp_box_height),
      .rsp_best_score (rsp_best_score)
   );

endmodule

### sim/tb_detection_best_box_selector_top.sv
// ----------------------------------------------------------------------------
// Detection best-box selector testbench
// Streams detector candidates into the selector under random idling on the
// request and result sides. Register settings change between phases, while the
// block is drained, and sometimes in the middle of a frame. A small tracker
// follows the kept box of the open frame and predicts each frame result, which
// is compared field by field with what the block returns.
// ----------------------------------------------------------------------------
module tb_detection_best_box_selector_top;

   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASES = 11;
   localparam int ITEMS_PER_PHASE = 170;

   typedef struct {
      logic [15:0]        score;
      logic signed [16:0] left;
      logic signed [16:0] top;
      logic signed [16:0] right;
      logic signed [16:0] bottom;
      logic               last;
   } candidate_type;

   typedef struct {
      logic        found;
      logic [11:0] box_x;
      logic [11:0] box_y;
      logic [11:0] box_width;
      logic [11:0] box_height;
      logic [15:0] top_score;
   } frame_result_type;

   class best_box_tracker;
      dbbs_pkg::cfg_type cfg;
      logic [15:0]       kept_score;
      logic [11:0]       kept_left, kept_top, kept_width, kept_height;
      bit                any_kept;
      logic [12:0]       cand_count;
      frame_result_type  pending[$];
      int                mismatches;

      function new();
         cfg = dbbs_pkg::CFG_RESET;
         mismatches = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         kept_score = '0;
         kept_left = '0;
         kept_top = '0;
         kept_width = '0;
         kept_height = '0;
         any_kept = 0;
         cand_count = '0;
      endfunction

      function void write_register(dbbs_pkg::csr_index_type idx, logic [15:0] data);
         case (idx)
            dbbs_pkg::REG_SCREEN_WIDTH:    cfg.screen_width = data[11:0];
            dbbs_pkg::REG_SCREEN_HEIGHT:   cfg.screen_height = data[11:0];
            dbbs_pkg::REG_SCORE_THRESHOLD: cfg.score_floor = data;
            dbbs_pkg::REG_MIN_BOX_WIDTH:   cfg.min_box_width = data[11:0];
            dbbs_pkg::REG_MAX_BOX_WIDTH:   cfg.max_box_width = data[11:0];
            dbbs_pkg::REG_MIN_BOX_HEIGHT:  cfg.min_box_height = data[11:0];
            dbbs_pkg::REG_MAX_BOX_HEIGHT:  cfg.max_box_height = data[11:0];
            dbbs_pkg::REG_EDGE_MARGIN:     cfg.edge_margin = data[7:0];
            default: ;
         endcase
      endfunction

      function int unsigned to_pixels(logic signed [16:0] norm, logic [11:0] dim);
         int unsigned n;
         n = 32'(norm);
         return (n * dim) >> 15;
      endfunction

      function int fit_on_screen(int pos, int dim, int size, int margin);
         int upper;
         int v;
         upper = dim - size - margin;
         v = (pos < upper) ? pos : upper;
         return (v > margin) ? v : margin;
      endfunction

      function void take_candidate(candidate_type c);
         int unsigned      x1, y1, x2, y2, w, h;
         int               bx, by;
         bit               at_limit;
         frame_result_type r;
         if (c.score > cfg.score_floor && c.left >= 0 && c.top >= 0 &&
             c.right <= dbbs_pkg::ONE_Q15 && c.bottom <= dbbs_pkg::ONE_Q15 &&
             c.right > c.left && c.bottom > c.top) begin
            x1 = to_pixels(c.left, cfg.screen_width);
            y1 = to_pixels(c.top, cfg.screen_height);
            x2 = to_pixels(c.right, cfg.screen_width);
            y2 = to_pixels(c.bottom, cfg.screen_height);
            w = x2 - x1;
            h = y2 - y1;
            if (w >= cfg.min_box_width && w <= cfg.max_box_width &&
                h >= cfg.min_box_height && h <= cfg.max_box_height &&
                c.score > kept_score) begin
               kept_score = c.score;
               kept_left = x1[11:0];
               kept_top = y1[11:0];
               kept_width = w[11:0];
               kept_height = h[11:0];
               any_kept = 1;
            end
         end
         cand_count = cand_count + 13'd1;
         at_limit = cand_count >= dbbs_pkg::CANDIDATE_LIMIT;
         if (!c.last && !at_limit)
            return;
         r = '{default: '0};
         if (any_kept && kept_score > cfg.score_floor) begin
            bx = fit_on_screen(int'(kept_left), int'(cfg.screen_width),
                               int'(kept_width), int'(cfg.edge_margin));
            by = fit_on_screen(int'(kept_top), int'(cfg.screen_height),
                               int'(kept_height), int'(cfg.edge_margin));
            r.found = 1'b1;
            r.box_x = bx[11:0];
            r.box_y = by[11:0];
            r.box_width = kept_width;
            r.box_height = kept_height;
            r.top_score = kept_score;
         end
         pending.push_back(r);
         clear_frame();
      endfunction

      task report_mismatch(string msg);
         mismatches++;
         $display("mismatch at %0t: %s", $time, msg);
      endtask

      task compare_frame_result(frame_result_type got);
         frame_result_type want;
         if (pending.size() == 0) begin
            report_mismatch("frame result arrived with none outstanding");
            return;
         end
         want = pending.pop_front();
         if (got.found !== want.found)
            report_mismatch($sformatf("found %0d, want %0d", got.found, want.found));
         if (got.box_x !== want.box_x)
            report_mismatch($sformatf("box_x %0d, want %0d", got.box_x, want.box_x));
         if (got.box_y !== want.box_y)
            report_mismatch($sformatf("box_y %0d, want %0d", got.box_y, want.box_y));
         if (got.box_width !== want.box_width)
            report_mismatch($sformatf("box_width %0d, want %0d",
                                      got.box_width, want.box_width));
         if (got.box_height !== want.box_height)
            report_mismatch($sformatf("box_height %0d, want %0d",
                                      got.box_height, want.box_height));
         if (got.top_score !== want.top_score)
            report_mismatch($sformatf("score %0d, want %0d",
                                      got.top_score, want.top_score));
      endtask
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [15:0]        req_score = '0;
   logic signed [16:0] req_left_norm = '0;
   logic signed [16:0] req_top_norm = '0;
   logic signed [16:0] req_right_norm = '0;
   logic signed [16:0] req_bottom_norm = '0;
   logic               req_last = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_found;
   logic [11:0]        rsp_box_x;
   logic [11:0]        rsp_box_y;
   logic [11:0]        rsp_box_width;
   logic [11:0]        rsp_box_height;
   logic [15:0]        rsp_best_score;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [2:0]         csr_index = '0;
   logic [15:0]        csr_data = '0;

   best_box_tracker  tracker;
   frame_result_type seen_result;
   int               cycle_count = 0;
   int               stall_run = 0;
   bit               stall_mode = 1'b0;
   int               steady_left = 0;
   int               frame_left = 0;
   logic [15:0]      prev_score = '0;

   detection_best_box_selector_top dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_score(req_score),
      .req_left_norm(req_left_norm),
      .req_top_norm(req_top_norm),
      .req_right_norm(req_right_norm),
      .req_bottom_norm(req_bottom_norm),
      .req_last(req_last),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_found(rsp_found),
      .rsp_box_x(rsp_box_x),
      .rsp_box_y(rsp_box_y),
      .rsp_box_width(rsp_box_width),
      .rsp_box_height(rsp_box_height),
      .rsp_best_score(rsp_best_score),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_run == 0) begin
            stall_mode = !stall_mode;
            if (stall_mode)
               stall_run = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40)
                                                       : $urandom_range(1, 3);
            else
               stall_run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                       : $urandom_range(1, 30);
         end
         stall_run = stall_run - 1;
         rsp_stall <= stall_mode;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         seen_result = '{rsp_found, rsp_box_x, rsp_box_y, rsp_box_width,
                         rsp_box_height, rsp_best_score};
         tracker.compare_frame_result(seen_result);
      end
   end

   task automatic send_candidate(candidate_type c);
      bit taken;
      taken = 0;
      req_valid = 1'b1;
      req_score = c.score;
      req_left_norm = c.left;
      req_top_norm = c.top;
      req_right_norm = c.right;
      req_bottom_norm = c.bottom;
      req_last = c.last;
      while (!taken) begin
         @(posedge clock);
         taken = !req_stall;
         if (taken)
            tracker.take_candidate(c);
         @(negedge clock);
      end
   endtask

   task automatic pause_requester();
      int pick;
      int gap;
      pick = $urandom_range(0, 99);
      if (steady_left > 0) begin
         steady_left--;
         gap = 0;
      end else if (pick < 60) begin
         gap = 0;
      end else if (pick < 95) begin
         gap = $urandom_range(1, 3);
      end else begin
         gap = $urandom_range(8, 40);
      end
      if ($urandom_range(0, 49) == 0)
         steady_left = $urandom_range(20, 60);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic drain_results();
      req_valid = 1'b0;
      while (tracker.pending.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(dbbs_pkg::csr_index_type idx, logic [15:0] data);
      bit done;
      done = 0;
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = data;
      while (!done) begin
         @(posedge clock);
         done = csr_ready;
         if (done)
            tracker.write_register(idx, data);
         @(negedge clock);
      end
   endtask

   task automatic apply_settings(dbbs_pkg::cfg_type s, bit dirty);
      logic [15:0] junk;
      junk = dirty ? 16'($urandom) : 16'd0;
      drain_results();
      csr_write(dbbs_pkg::REG_SCREEN_WIDTH, {junk[15:12], s.screen_width});
      csr_write(dbbs_pkg::REG_SCREEN_HEIGHT, {junk[15:12], s.screen_height});
      csr_write(dbbs_pkg::REG_SCORE_THRESHOLD, s.score_floor);
      csr_write(dbbs_pkg::REG_MIN_BOX_WIDTH, {junk[15:12], s.min_box_width});
      csr_write(dbbs_pkg::REG_MAX_BOX_WIDTH, {junk[15:12], s.max_box_width});
      csr_write(dbbs_pkg::REG_MIN_BOX_HEIGHT, {junk[15:12], s.min_box_height});
      csr_write(dbbs_pkg::REG_MAX_BOX_HEIGHT, {junk[15:12], s.max_box_height});
      csr_write(dbbs_pkg::REG_EDGE_MARGIN, {junk[15:8], s.edge_margin});
      csr_valid = 1'b0;
   endtask

   function automatic dbbs_pkg::cfg_type settings_for_phase(int phase);
      dbbs_pkg::cfg_type s;
      case (phase)
         1: s = '{12'd4095, 12'd4095, 16'd0, 12'd0, 12'd4095, 12'd0, 12'd4095, 8'd0};
         2: s = '{12'd1, 12'd1, 16'd32768, 12'd0, 12'd0, 12'd0, 12'd0, 8'd255};
         3: s = '{12'd4095, 12'd16, 16'd0, 12'd0, 12'd4095, 12'd0, 12'd3, 8'd255};
         4: s = '{12'd640, 12'd480, 16'd65534, 12'd0, 12'd4095, 12'd0, 12'd4095, 8'd255};
         5: s = dbbs_pkg::CFG_RESET;
         default: begin
            s.screen_width = 12'($urandom_range(0, 1) ? $urandom_range(64, 800)
                                                      : $urandom_range(1, 4095));
            s.screen_height = 12'($urandom_range(0, 1) ? $urandom_range(64, 800)
                                                       : $urandom_range(1, 4095));
            s.score_floor = 16'($urandom_range(0, 32768));
            s.min_box_width = 12'($urandom_range(0, 200));
            s.max_box_width = 12'(s.min_box_width + $urandom_range(0, 600));
            s.min_box_height = 12'($urandom_range(0, 200));
            s.max_box_height = 12'(s.min_box_height + $urandom_range(0, 600));
            s.edge_margin = 8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                           : $urandom_range(0, 20));
         end
      endcase
      return s;
   endfunction

   function automatic candidate_type make_candidate(bit noisy, bit last);
      candidate_type c;
      int unsigned   thr;
      int unsigned   hi;
      thr = 32'(tracker.cfg.score_floor);
      hi = (thr < 32768) ? 32768 : 65535;
      if (noisy) begin
         c.score = 16'($urandom);
         c.left = 17'($urandom);
         c.top = 17'($urandom);
         c.right = 17'($urandom);
         c.bottom = 17'($urandom);
      end else begin
         case ($urandom_range(0, 9))
            0: c.score = prev_score;
            1: c.score = 16'(thr - 1 + $urandom_range(0, 2));
            default: c.score = 16'($urandom_range(hi, thr + 1));
         endcase
         c.left = 17'(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 32767));
         c.right = 17'(($urandom_range(0, 3) == 0) ? 32768
                                                   : $urandom_range(32768, c.left + 1));
         c.top = 17'(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 32767));
         c.bottom = 17'(($urandom_range(0, 3) == 0) ? 32768
                                                    : $urandom_range(32768, c.top + 1));
      end
      c.last = last;
      prev_score = c.score;
      return c;
   endfunction

   task automatic send_directed(int score, int l, int t, int r, int b, bit last);
      candidate_type c;
      c.score = 16'(score);
      c.left = 17'(l);
      c.top = 17'(t);
      c.right = 17'(r);
      c.bottom = 17'(b);
      c.last = last;
      send_candidate(c);
      pause_requester();
   endtask

   task automatic run_random(int count, int phase);
      bit last;
      for (int i = 0; i < count; i++) begin
         if (i == 0 && phase == 4)
            frame_left = 500;
         else if (i == 0 && phase == 9)
            frame_left = 510;
         else if (frame_left == 0)
            frame_left = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 10)
                                                      : $urandom_range(11, 60);
         last = (frame_left == 1);
         frame_left--;
         if ($urandom_range(0, 99) < 3)
            last = 1'($urandom_range(0, 1));
         send_candidate(make_candidate($urandom_range(0, 99) < 25, last));
         pause_requester();
         if ($urandom_range(0, 99) == 0)
            drain_results();
      end
   endtask

   initial begin
      tracker = new();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_directed(20000, 3277, 3277, 16384, 16384, 0);
      send_directed(20000, 0, 0, 8192, 16384, 0);
      send_directed(32768, 0, 0, 32768, 32768, 0);
      send_directed(16384, 3277, 3277, 16384, 16384, 0);
      send_directed(0, 3277, 3277, 16384, 16384, 0);
      send_directed(30000, -1, 0, 16384, 16384, 0);
      send_directed(30000, 0, -65536, 16384, 16384, 0);
      send_directed(30000, 0, 0, 32769, 16384, 0);
      send_directed(30000, 0, 0, 16384, 65535, 0);
      send_directed(30000, 16384, 0, 16384, 16384, 0);
      send_directed(30000, 0, 20000, 16384, 10000, 0);
      send_directed(65535, 26000, 20000, 32768, 32768, 1);
      send_directed(20000, 0, 0, 16384, 16384, 1);
      send_directed(1000, 0, 0, 1, 1, 1);
      send_directed(20000, 3277, 3277, 16384, 16384, 0);
      drain_results();
      csr_write(dbbs_pkg::REG_SCORE_THRESHOLD, 16'd25000);
      csr_valid = 1'b0;
      send_directed(0, 0, 0, 0, 0, 1);
      send_directed(32768, 0, 0, 8192, 10923, 1);

      for (int phase = 1; phase <= PHASES; phase++) begin
         apply_settings(settings_for_phase(phase), phase >= 6 && $urandom_range(0, 3) == 0);
         run_random(ITEMS_PER_PHASE, phase);
      end

      drain_results();
      if (tracker.mismatches == 0)
         $display("detection_best_box_selector_top regression: pass");
      else
         $display("detection_best_box_selector_top regression: fail");
      $finish;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("detection_best_box_selector_top regression: fail");
      $finish;
   end

endmodule

### files.f
sv/dbbs_pkg.sv
sv/dbbs_csr.sv
sv/dbbs_scale.sv
sv/dbbs_select.sv
sv/detection_best_box_selector_top.sv
sim/tb_detection_best_box_selector_top.sv
